FILE: hw/rtl/round_robin_eligible_picker_unit_macros.svh
// assertion macros for the round-robin eligible picker
// used by the checker module; needs clk and rst in the enclosing scope
`ifndef ROUND_ROBIN_ELIGIBLE_PICKER_UNIT_MACROS_SVH
`define ROUND_ROBIN_ELIGIBLE_PICKER_UNIT_MACROS_SVH

// checked only outside reset
`define RREP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define RREP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rrep_pkg.sv
// shared types and constants of the round-robin eligible picker
// no dependencies; used by every rtl file of the block but rrep_ram
package rrep_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int MODE_W = 2;
  localparam int KEY_W  = 32;
  localparam int LOAD_W = 10;
  localparam int TIME_W = 32;
  localparam int LIM_W  = 8;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 8;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = (LIM_W > LOAD_W) ? LIM_W : LOAD_W;

  localparam int IN_FIELDS_W  = KEY_W + 1 + LOAD_W + TIME_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W    = MODE_W;
  localparam int OUT_FIELDS_W = KEY_W + TIME_W + OCNT_W + OCNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_USER_W   = STAT_W;

  localparam logic [MODE_W-1:0] MODE_REG   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNREG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCHED = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_CAP    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESH = 1'b1;

  localparam logic [LIM_W-1:0]  DEFAULT_LIMIT = LIM_W'(100);
  localparam logic [LOAD_W-1:0] THRESH_RESET  = LOAD_W'(900);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              avail;
    logic [LOAD_W-1:0] load;
    logic [TIME_W-1:0] resp_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic              avail;
    logic [LOAD_W-1:0] load;
    logic [TIME_W-1:0] resp_time;
  } cmd_t;

  typedef struct packed {
    logic [LIM_W-1:0]  capacity_limit;
    logic [LOAD_W-1:0] load_threshold;
  } cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  picked_key;
    logic [TIME_W-1:0] picked_time_ms;
    logic [OCNT_W-1:0] total_count;
    logic [OCNT_W-1:0] avail_count;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REG_SCAN,
    S_RM_SCAN,
    S_RM_SHIFT,
    S_SCH_FIX,
    S_SCH_SCAN,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/rrep_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rrep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rrep_engine.sv
// sequencer and shared scan unit of the picker: key match, removal shift,
// eligibility scan, one table entry per cycle; uses rrep_pkg and rrep_ram
module rrep_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rrep_pkg::cmd_t      cmd_in,
  input  rrep_pkg::cfg_t      cfg,
  input  logic                res_ready,
  output logic                idle,
  output logic                res_valid,
  output rrep_pkg::res_t      res
);

  localparam int LW = (rrep_pkg::LIM_W > rrep_pkg::CNT_W) ? rrep_pkg::LIM_W
                                                          : rrep_pkg::CNT_W;

  rrep_pkg::state_t state, state_next;

  logic [rrep_pkg::CNT_W-1:0]  count, count_next;
  logic [rrep_pkg::CNT_W-1:0]  avail_cnt, avail_cnt_next;
  logic [rrep_pkg::IDX_W-1:0]  ptr, ptr_next;
  logic [rrep_pkg::CNT_W-1:0]  ra, ra_next;
  logic [rrep_pkg::CNT_W-1:0]  nis, nis_next;
  logic                        rd_vld, rd_vld_next;
  logic [rrep_pkg::IDX_W-1:0]  da, da_next;
  rrep_pkg::cmd_t              cmd, cmd_next;
  logic [rrep_pkg::STAT_W-1:0] status, status_next;
  logic [rrep_pkg::KEY_W-1:0]  pk, pk_next;
  logic [rrep_pkg::TIME_W-1:0] pt, pt_next;

  logic                         ram_we;
  logic [rrep_pkg::IDX_W-1:0]   ram_waddr;
  logic [rrep_pkg::ENTRY_W-1:0] ram_wdata;
  logic [rrep_pkg::ENTRY_W-1:0] ram_rdata;
  rrep_pkg::entry_t             rd_e;
  rrep_pkg::entry_t             new_e;

  logic [LW-1:0]              lim_raw;
  logic [LW-1:0]              lim_eff;
  logic [rrep_pkg::CNT_W-1:0] ptr_ext;
  logic [rrep_pkg::CNT_W-1:0] da_inc;
  logic [rrep_pkg::CNT_W-1:0] ra_inc;
  logic [rrep_pkg::CNT_W-1:0] count_dec;
  logic                       issue_ok;
  logic                       key_hit;
  logic                       elig;

  rrep_ram #(
    .WIDTH (rrep_pkg::ENTRY_W),
    .DEPTH (rrep_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ra[rrep_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_e      = rrep_pkg::entry_t'(ram_rdata);
  assign new_e     = '{key: cmd.key, avail: cmd.avail, load: cmd.load,
                       resp_time: cmd.resp_time};
  assign lim_raw   = (cfg.capacity_limit == '0) ? LW'(rrep_pkg::DEFAULT_LIMIT)
                                                : LW'(cfg.capacity_limit);
  assign lim_eff   = (lim_raw > LW'(rrep_pkg::MAX_ENTRIES)) ? LW'(rrep_pkg::MAX_ENTRIES)
                                                            : lim_raw;
  assign ptr_ext   = rrep_pkg::CNT_W'(ptr);
  assign da_inc    = rrep_pkg::CNT_W'(da) + 1'b1;
  assign ra_inc    = ra + 1'b1;
  assign count_dec = count - 1'b1;
  assign issue_ok  = (ra < count);
  assign key_hit   = rd_vld && (rd_e.key == cmd.key);
  assign elig      = rd_vld && rd_e.avail && (rd_e.load < cfg.load_threshold);

  assign idle      = (state == rrep_pkg::S_IDLE);
  assign res_valid = (state == rrep_pkg::S_DONE);
  assign res       = '{status: status, picked_key: pk, picked_time_ms: pt,
                       total_count: rrep_pkg::OCNT_W'(count),
                       avail_count: rrep_pkg::OCNT_W'(avail_cnt)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrep_pkg::S_IDLE;
      count     <= '0;
      avail_cnt <= '0;
      ptr       <= '0;
      rd_vld    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      avail_cnt <= avail_cnt_next;
      ptr       <= ptr_next;
      rd_vld    <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    ra     <= ra_next;
    nis    <= nis_next;
    da     <= da_next;
    cmd    <= cmd_next;
    status <= status_next;
    pk     <= pk_next;
    pt     <= pt_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    avail_cnt_next = avail_cnt;
    ptr_next       = ptr;
    ra_next        = ra;
    nis_next       = nis;
    rd_vld_next    = 1'b0;
    da_next        = ra[rrep_pkg::IDX_W-1:0];
    cmd_next       = cmd;
    status_next    = status;
    pk_next        = pk;
    pt_next        = pt;
    ram_we         = 1'b0;
    ram_waddr      = da;
    ram_wdata      = ram_rdata;

    unique case (state)
      rrep_pkg::S_IDLE: begin
        if (start) begin
          cmd_next = cmd_in;
          pk_next  = '0;
          pt_next  = '0;
          ra_next  = '0;
          nis_next = '0;
          unique case (cmd_in.mode)
            rrep_pkg::MODE_REG: begin
              if (LW'(count) >= lim_eff) begin
                status_next = rrep_pkg::ST_OVERFLOW;
                state_next  = rrep_pkg::S_DONE;
              end else begin
                state_next = rrep_pkg::S_REG_SCAN;
              end
            end
            rrep_pkg::MODE_UNREG: begin
              state_next = rrep_pkg::S_RM_SCAN;
            end
            rrep_pkg::MODE_SCHED: begin
              if (count == '0) begin
                status_next = rrep_pkg::ST_NOT_FOUND;
                state_next  = rrep_pkg::S_DONE;
              end else if (ptr_ext >= count) begin
                // stale pointer: first try fails, pointer wraps modulo count
                ra_next    = ptr_ext + 1'b1;
                nis_next   = rrep_pkg::CNT_W'(1);
                state_next = rrep_pkg::S_SCH_FIX;
              end else begin
                ra_next    = ptr_ext;
                state_next = rrep_pkg::S_SCH_SCAN;
              end
            end
            default: begin
              status_next = rrep_pkg::ST_NOT_FOUND;
              state_next  = rrep_pkg::S_DONE;
            end
          endcase
        end
      end

      rrep_pkg::S_REG_SCAN: begin
        if (key_hit) begin
          ram_we         = 1'b1;
          ram_waddr      = da;
          ram_wdata      = new_e;
          avail_cnt_next = avail_cnt - rrep_pkg::CNT_W'(rd_e.avail)
                           + rrep_pkg::CNT_W'(cmd.avail);
          status_next    = rrep_pkg::ST_OK;
          state_next     = rrep_pkg::S_DONE;
        end else if (!rd_vld && !issue_ok) begin
          ram_we         = 1'b1;
          ram_waddr      = count[rrep_pkg::IDX_W-1:0];
          ram_wdata      = new_e;
          count_next     = count + 1'b1;
          avail_cnt_next = avail_cnt + rrep_pkg::CNT_W'(cmd.avail);
          status_next    = rrep_pkg::ST_OK;
          state_next     = rrep_pkg::S_DONE;
        end else if (issue_ok) begin
          ra_next     = ra_inc;
          rd_vld_next = 1'b1;
        end
      end

      rrep_pkg::S_RM_SCAN: begin
        if (key_hit) begin
          avail_cnt_next = avail_cnt - rrep_pkg::CNT_W'(rd_e.avail);
          ra_next        = da_inc;
          state_next     = rrep_pkg::S_RM_SHIFT;
        end else if (!rd_vld && !issue_ok) begin
          status_next = rrep_pkg::ST_NOT_FOUND;
          state_next  = rrep_pkg::S_DONE;
        end else if (issue_ok) begin
          ra_next     = ra_inc;
          rd_vld_next = 1'b1;
        end
      end

      rrep_pkg::S_RM_SHIFT: begin
        if (rd_vld) begin
          ram_we    = 1'b1;
          ram_waddr = da - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (issue_ok) begin
          ra_next     = ra_inc;
          rd_vld_next = 1'b1;
        end else if (!rd_vld) begin
          count_next = count_dec;
          if ((count_dec != '0) && (ptr_ext >= count_dec)) begin
            ptr_next = '0;
          end
          status_next = rrep_pkg::ST_OK;
          state_next  = rrep_pkg::S_DONE;
        end
      end

      rrep_pkg::S_SCH_FIX: begin
        if (ra >= count) begin
          ra_next = ra - count;
        end else begin
          ptr_next   = ra[rrep_pkg::IDX_W-1:0];
          state_next = rrep_pkg::S_SCH_SCAN;
        end
      end

      rrep_pkg::S_SCH_SCAN: begin
        if (rd_vld) begin
          ptr_next = (da_inc == count) ? '0 : da_inc[rrep_pkg::IDX_W-1:0];
        end
        if (elig) begin
          pk_next     = rd_e.key;
          pt_next     = rd_e.resp_time;
          status_next = rrep_pkg::ST_OK;
          state_next  = rrep_pkg::S_DONE;
        end else if (!rd_vld && (nis >= count)) begin
          status_next = rrep_pkg::ST_NOT_FOUND;
          state_next  = rrep_pkg::S_DONE;
        end else if (nis < count) begin
          ra_next     = (ra_inc == count) ? '0 : ra_inc;
          nis_next    = nis + 1'b1;
          rd_vld_next = 1'b1;
        end
      end

      rrep_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = rrep_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rrep_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/round_robin_eligible_picker_unit.sv
// Round-robin picker over a table of up to MAX_ENTRIES worker entries kept in
// one ram with a single read and a single write port. One transaction is
// worked on at a time and s_tready stays low until it is done. A register or
// update makes one key compare per entry; an unregister shares one pass
// between the key search and the shift of the later entries; a schedule makes
// up to one eligibility check per entry, after first rewrapping a pointer left
// past the end after the table was emptied. A full-table register, an
// empty-table schedule and an unknown mode go straight to the result with no
// scan. The result waits in an output register, so the picker is free again
// as soon as the result has been handed over. Depends on rrep_pkg,
// rrep_engine and rrep_ram.
module round_robin_eligible_picker_unit (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [rrep_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rrep_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // worker_key, avail_flag, load_permille, resp_time_ms, zero pad
  input  logic [rrep_pkg::IN_DATA_W-1:0]      s_tdata,
  // mode
  input  logic [rrep_pkg::IN_USER_W-1:0]      s_tuser,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // picked_key, picked_time_ms, total_count, avail_count
  output logic [rrep_pkg::OUT_DATA_W-1:0]     m_tdata,
  // status
  output logic [rrep_pkg::OUT_USER_W-1:0]     m_tuser
);

  localparam int KEY_LO  = 0;
  localparam int AV_LO   = KEY_LO + rrep_pkg::KEY_W;
  localparam int LOAD_LO = AV_LO + 1;
  localparam int TIME_LO = LOAD_LO + rrep_pkg::LOAD_W;

  rrep_pkg::cfg_t cfg;
  rrep_pkg::cmd_t cmd_in;
  rrep_pkg::res_t res;
  rrep_pkg::res_t out_res;
  logic           eng_idle;
  logic           res_valid;
  logic           res_ready;
  logic           start;

  assign s_tready  = eng_idle;
  assign start     = s_tvalid && s_tready;
  assign res_ready = !m_tvalid || m_tready;

  assign cmd_in = '{
    mode:      s_tuser[rrep_pkg::MODE_W-1:0],
    key:       s_tdata[KEY_LO +: rrep_pkg::KEY_W],
    avail:     s_tdata[AV_LO],
    load:      s_tdata[LOAD_LO +: rrep_pkg::LOAD_W],
    resp_time: s_tdata[TIME_LO +: rrep_pkg::TIME_W]
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity_limit <= rrep_pkg::DEFAULT_LIMIT;
      cfg.load_threshold <= rrep_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rrep_pkg::CFG_CAP: begin
          cfg.capacity_limit <= cfg_wdata[rrep_pkg::LIM_W-1:0];
        end
        rrep_pkg::CFG_THRESH: begin
          cfg.load_threshold <= cfg_wdata[rrep_pkg::LOAD_W-1:0];
        end
      endcase
    end
  end

  rrep_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd_in    (cmd_in),
    .cfg       (cfg),
    .res_ready (res_ready),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tuser = rrep_pkg::OUT_USER_W'(out_res.status);
  assign m_tdata = rrep_pkg::OUT_DATA_W'({out_res.avail_count, out_res.total_count,
                                          out_res.picked_time_ms, out_res.picked_key});

endmodule

FILE: hw/rtl/rrep_chk.sv
// port-level checker for the round-robin eligible picker, bound to the top
// depends on rrep_pkg and round_robin_eligible_picker_unit_macros.svh
`include "round_robin_eligible_picker_unit_macros.svh"

module rrep_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [rrep_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [rrep_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [rrep_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [rrep_pkg::IN_USER_W-1:0]  s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rrep_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [rrep_pkg::OUT_USER_W-1:0] m_tuser
);

  `RREP_ASSERT_ALWAYS(a_rst_no_result, rst |=> !m_tvalid, "result valid after reset")
  `RREP_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready during work")
  `RREP_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `RREP_ASSERT(a_fail_zero_pick, m_tvalid && (m_tuser != rrep_pkg::ST_OK) |-> (m_tdata[63:0] == '0), "pick on failure")
  `RREP_ASSERT(a_avail_le_total, m_tvalid |-> (m_tdata[79:72] <= m_tdata[71:64]), "avail above total")

endmodule

bind round_robin_eligible_picker_unit rrep_chk u_rrep_chk (.*);

FILE: tb/sv/tb_round_robin_eligible_picker_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for round_robin_eligible_picker_unit: a directed table,
// then randomized register, unregister, schedule and unknown-mode traffic checked
// against a table predictor; depends on rrep_pkg and the picker rtl
module tb_round_robin_eligible_picker_unit;
  import rrep_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int POOL_N = 160;
  localparam int N_DIRECTED = 23;
  localparam int N_PHASES = 6;
  localparam res_t NO_RES = '0;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic              avail;
    logic [LOAD_W-1:0] load;
    logic [TIME_W-1:0] resp_time;
    logic              typed;
    res_t              typed_res;
  } stim_row_t;

  typedef struct packed {
    logic [LIM_W-1:0]  cap;
    logic [LOAD_W-1:0] thresh;
    logic [15:0]       items;
    logic [7:0]        reg_pct;
    logic [7:0]        unreg_pct;
    logic [7:0]        pool_n;
    logic              fill;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  // predictor copy of the worker table
  logic [KEY_W-1:0]  tbl_key   [MAX_ENTRIES];
  logic              tbl_avail [MAX_ENTRIES];
  logic [LOAD_W-1:0] tbl_load  [MAX_ENTRIES];
  logic [TIME_W-1:0] tbl_time  [MAX_ENTRIES];
  int tbl_count = 0;
  int rr_ptr = 0;
  logic [LIM_W-1:0]  cap_reg = DEFAULT_LIMIT;
  logic [LOAD_W-1:0] thresh_reg = THRESH_RESET;

  res_t expected_results [$];
  logic [KEY_W-1:0] key_pool [POOL_N];
  int n_sent = 0;
  int fails = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    {MODE_SCHED, 32'h0, 1'b0, 10'd0, 32'h0, 1'b1, {ST_NOT_FOUND, 64'h0, 8'd0, 8'd0}},
    {MODE_NONE, 32'hffffffff, 1'b1, 10'd1023, 32'hffffffff, 1'b1,
     {ST_NOT_FOUND, 64'h0, 8'd0, 8'd0}},
    {MODE_UNREG, 32'hffffffff, 1'b0, 10'd0, 32'h0, 1'b1, {ST_NOT_FOUND, 64'h0, 8'd0, 8'd0}},
    {MODE_REG, 32'h0, 1'b1, 10'd0, 32'h0, 1'b1, {ST_OK, 64'h0, 8'd1, 8'd1}},
    {MODE_REG, 32'hffffffff, 1'b1, 10'd1023, 32'hffffffff, 1'b1, {ST_OK, 64'h0, 8'd2, 8'd2}},
    {MODE_REG, 32'h12345678, 1'b0, 10'd899, 32'h5, 1'b1, {ST_OK, 64'h0, 8'd3, 8'd2}},
    {MODE_REG, 32'ha5a5a5a5, 1'b1, 10'd899, 32'hdeadbeef, 1'b1, {ST_OK, 64'h0, 8'd4, 8'd3}},
    {MODE_SCHED, 32'h0, 1'b0, 10'd0, 32'h0, 1'b1, {ST_OK, 32'h0, 32'h0, 8'd4, 8'd3}},
    {MODE_SCHED, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_SCHED, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    // update in place, load right at the threshold
    {MODE_REG, 32'h12345678, 1'b1, 10'd900, 32'h7, 1'b0, NO_RES},
    {MODE_REG, 32'h5a5a5a5a, 1'b1, 10'd1, 32'hffffffff, 1'b0, NO_RES},
    {MODE_SCHED, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_SCHED, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_UNREG, 32'hffffffff, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_UNREG, 32'h0000abcd, 1'b1, 10'd5, 32'h9, 1'b0, NO_RES},
    {MODE_NONE, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_UNREG, 32'h5a5a5a5a, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_SCHED, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_UNREG, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_UNREG, 32'h12345678, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_UNREG, 32'ha5a5a5a5, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES},
    {MODE_SCHED, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0, NO_RES}
  };

  phase_t phase_plan [N_PHASES] = '{
    {8'd4,   10'd500,  16'd200, 8'd50, 8'd25, 8'd8,   1'b0},
    {8'd128, 10'd1023, 16'd170, 8'd50, 8'd20, 8'd160, 1'b1},
    {8'd1,   10'd0,    16'd250, 8'd15, 8'd65, 8'd160, 1'b0},
    {8'd100, 10'd900,  16'd350, 8'd45, 8'd20, 8'd120, 1'b0},
    {8'd16,  10'd1,    16'd200, 8'd45, 8'd25, 8'd24,  1'b0},
    {8'd128, 10'd512,  16'd300, 8'd40, 8'd25, 8'd160, 1'b0}
  };

  round_robin_eligible_picker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial forever #4 clk = ~clk;

  function automatic res_t table_step(input logic [MODE_W-1:0] md,
                                      input logic [KEY_W-1:0] key, input logic av,
                                      input logic [LOAD_W-1:0] ld,
                                      input logic [TIME_W-1:0] tm);
    res_t r;
    int hit;
    int lim;
    int slot;
    int i;
    int p;
    int n_avail;
    bit found;
    r = '0;
    hit = -1;
    found = 1'b0;
    n_avail = 0;
    for (i = 0; i < tbl_count; i++)
      if (hit < 0 && tbl_key[i] == key) hit = i;
    case (md)
      MODE_REG: begin
        lim = (cap_reg == 0) ? int'(DEFAULT_LIMIT) : int'(cap_reg);
        if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
        // limit is checked before the key match
        if (tbl_count >= lim) begin
          r.status = ST_OVERFLOW;
        end else begin
          slot = (hit >= 0) ? hit : tbl_count;
          tbl_key[slot] = key;
          tbl_avail[slot] = av;
          tbl_load[slot] = ld;
          tbl_time[slot] = tm;
          if (hit < 0) tbl_count++;
          r.status = ST_OK;
        end
      end
      MODE_UNREG: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_avail[i] = tbl_avail[i + 1];
            tbl_load[i] = tbl_load[i + 1];
            tbl_time[i] = tbl_time[i + 1];
          end
          tbl_count--;
          if (tbl_count > 0 && rr_ptr >= tbl_count) rr_ptr = 0;
          r.status = ST_OK;
        end
      end
      MODE_SCHED: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < tbl_count && !found; i++) begin
          p = rr_ptr;
          rr_ptr = (p + 1) % tbl_count;
          if (p < tbl_count && tbl_avail[p] && tbl_load[p] < thresh_reg) begin
            found = 1'b1;
            r.status = ST_OK;
            r.picked_key = tbl_key[p];
            r.picked_time_ms = tbl_time[p];
          end
        end
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    for (i = 0; i < tbl_count; i++)
      if (tbl_avail[i]) n_avail++;
    r.total_count = OCNT_W'(tbl_count);
    r.avail_count = OCNT_W'(n_avail);
    return r;
  endfunction

  task automatic push_cmd(input logic [MODE_W-1:0] md, input logic [KEY_W-1:0] key,
                          input logic av, input logic [LOAD_W-1:0] ld,
                          input logic [TIME_W-1:0] tm, input logic typed,
                          input res_t typed_res);
    res_t pred;
    if (n_sent < 550) begin
      src_idle_pct = 28;
      snk_idle_pct = 87;
    end else if (n_sent < 1100) begin
      src_idle_pct = 87;
      snk_idle_pct = 28;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'({tm, ld, av, key});
    s_tuser <= md;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = table_step(md, key, av, ld, tm);
    expected_results.push_back(typed ? typed_res : pred);
    n_sent++;
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[KEY_W-1:0], m_tdata[KEY_W +: TIME_W],
               m_tdata[KEY_W+TIME_W +: OCNT_W], m_tdata[KEY_W+TIME_W+OCNT_W +: OCNT_W]};
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected transaction: status %0d key %h time %h total %0d avail %0d",
                     got.status, got.picked_key, got.picked_time_ms, got.total_count,
                     got.avail_count);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.picked_key !== want.picked_key ||
              got.picked_time_ms !== want.picked_time_ms ||
              got.total_count !== want.total_count ||
              got.avail_count !== want.avail_count) begin
            fails++;
            if (fails <= 10)
              $display("bad result: exp st %0d key %h time %h total %0d avail %0d",
                       want.status, want.picked_key, want.picked_time_ms,
                       want.total_count, want.avail_count, "\n",
                       "            got st %0d key %h time %h total %0d avail %0d",
                       got.status, got.picked_key, got.picked_time_ms,
                       got.total_count, got.avail_count);
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("round_robin_eligible_picker_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    phase_t cur;
    logic [MODE_W-1:0] md;
    logic [KEY_W-1:0] key;
    logic [LOAD_W-1:0] ld;
    int k;
    int ph;
    int r;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (k = 2; k < POOL_N; k++) key_pool[k] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < N_DIRECTED; k++) begin
      row = directed_rows[k];
      push_cmd(row.mode, row.key, row.avail, row.load, row.resp_time, row.typed,
               row.typed_res);
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      cur = phase_plan[ph];
      wait_all_results();
      cfg_we <= 1'b1;
      cfg_addr <= CFG_CAP;
      cfg_wdata <= CFG_DATA_W'(cur.cap);
      cap_reg = cur.cap;
      @(posedge clk);
      cfg_addr <= CFG_THRESH;
      cfg_wdata <= CFG_DATA_W'(cur.thresh);
      thresh_reg = cur.thresh;
      @(posedge clk);
      cfg_we <= 1'b0;

      // fill the whole table and run past the limit
      if (cur.fill)
        for (k = 0; k < MAX_ENTRIES + 2; k++)
          push_cmd(MODE_REG, key_pool[k], 1'($urandom_range(0, 1)),
                   LOAD_W'($urandom_range(0, 1023)), $urandom, 1'b0, NO_RES);

      for (k = 0; k < cur.items; k++) begin
        r = $urandom_range(0, 99);
        if (r < cur.reg_pct) md = MODE_REG;
        else if (r < cur.reg_pct + cur.unreg_pct) md = MODE_UNREG;
        else if (r < 95) md = MODE_SCHED;
        else md = MODE_NONE;
        key = ($urandom_range(0, 9) == 0) ? $urandom
                                          : key_pool[$urandom_range(0, cur.pool_n - 1)];
        ld = ($urandom_range(0, 3) == 0) ? LOAD_W'($urandom_range(0, 7))
                                         : LOAD_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 49) == 0) wait_all_results();
        push_cmd(md, key, ($urandom_range(0, 3) != 0), ld, $urandom, 1'b0, NO_RES);
      end
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("round_robin_eligible_picker_unit: match");
    end else begin
      $display("round_robin_eligible_picker_unit: mismatch");
    end
    $finish;
  end

endmodule
